[rtl/sliding_window_receiver_assert.svh]
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_RECEIVER_ASSERT_SVH
`define SLIDING_WINDOW_RECEIVER_ASSERT_SVH

// clocked check, masked while reset is applied
`define SWR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define SWR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/swr_pkg.sv]
package swr_pkg;

  // default build parameters
  localparam int SLOT_COUNT_DEF   = 32;
  localparam int MAX_PAYLOAD_DEF  = 1461;
  localparam int HEADER_BYTES_DEF = 11;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DROP           = 3'd0,
    KIND_ACK            = 3'd1,
    KIND_FINACK         = 3'd2,
    KIND_STORE          = 3'd3,
    KIND_DELIVER_SLOT   = 3'd4,
    KIND_DELIVER_DIRECT = 3'd5
  } kind_e;

  // packet classes found by the front
  typedef enum logic [1:0] {
    CLS_BAD  = 2'd0,
    CLS_FIN  = 2'd1,
    CLS_DATA = 2'd2
  } cls_e;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WINDOW = 2'd1;
  localparam logic [1:0] CFG_INIT   = 2'd2;

  typedef struct packed {
    cls_e        cls;
    logic [31:0] seq;
    logic [10:0] plen;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] ack_seq;
    logic [4:0]  slot;
    logic [10:0] bytes;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        mode_sr;
    logic [5:0]  win;
    logic [31:0] init_seq;
  } cfg_t;

endpackage

[rtl/swr_fifo.sv]
module swr_fifo
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
  )
  (
    input  logic             clk_i,
    input  logic             rst_ni,
    input  logic             push_i,
    input  logic [WIDTH-1:0] data_i,
    output logic             full_o,
    input  logic             pop_i,
    output logic [WIDTH-1:0] data_o,
    output logic             empty_o
  );

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/swr_front.sv]
module swr_front
  import swr_pkg::*;
  #(
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
  )
  (
    input  logic [31:0] seq_number_i,
    input  logic [15:0] payload_length_i,
    input  logic [10:0] received_bytes_i,
    input  logic        checksum_good_i,
    input  logic        flag_syn_i,
    input  logic        flag_ack_i,
    input  logic        flag_fin_i,
    output item_t       item_o
  );

  logic [16:0] len_sum;
  logic        len_ok;

  // length field plus header must match the datagram size
  assign len_sum = {1'b0, payload_length_i} + 17'(HEADER_BYTES);
  assign len_ok  = (payload_length_i <= 16'(MAX_PAYLOAD)) &&
                   (len_sum == {6'b0, received_bytes_i});

  always_comb begin
    item_o.seq  = seq_number_i;
    item_o.plen = payload_length_i[10:0];
    if (!len_ok || !checksum_good_i) begin
      item_o.cls = CLS_BAD;
    end else if (flag_fin_i && !flag_syn_i && !flag_ack_i) begin
      item_o.cls = CLS_FIN;
    end else if (flag_syn_i || flag_ack_i || flag_fin_i) begin
      item_o.cls = CLS_BAD;
    end else begin
      item_o.cls = CLS_DATA;
    end
  end

endmodule

[rtl/swr_back.sv]
module swr_back
  import swr_pkg::*;
  #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
  )
  (
    input  logic    clk_i,
    input  logic    rst_ni,
    input  cfg_t    cfg_i,
    input  logic    in_valid_i,
    input  item_t   in_item_i,
    output logic    in_pop_o,
    output logic    out_push_o,
    output result_t out_res_o,
    input  logic    out_full_i
  );

  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SUMW = $clog2(3 * SLOT_COUNT);
  localparam logic [63:0] TWO32 = 64'h1_0000_0000;
  localparam int WRAP_MOD = int'(TWO32 % SLOT_COUNT);
  localparam int CORR     = (SLOT_COUNT - WRAP_MOD) % SLOT_COUNT;
  localparam logic [SW-1:0] BASE_MOD_RST = SW'(1 % SLOT_COUNT);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXP    = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_DEC    = 3'd3;
  localparam logic [2:0] ST_ACK    = 3'd4;
  localparam logic [2:0] ST_STORE  = 3'd5;
  localparam logic [2:0] ST_DRN_RD = 3'd6;
  localparam logic [2:0] ST_DRN_EM = 3'd7;

  logic [2:0]            state_q;
  item_t                 item_q;
  logic [31:0]           base_q, exp_q, pnum_q, ahead_q, behind_q;
  logic [SW-1:0]         base_mod_q, slot_q, k_q, next_mod;
  logic                  done_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [10:0]           len_mem_q [SLOT_COUNT];
  logic [10:0]           rd_q;

  logic          zero, in_ahead, in_behind, in_win;
  logic          ok_item, gbn_deliver, fin_ok, do_store, drain_last, go;
  logic          ovf;
  logic [5:0]    d6;
  logic [SUMW-1:0] sum0, sum1, sum2;
  logic [SW+4:0] slot_x, base_x;

  // window tests on the registered distances
  assign zero      = (ahead_q == '0);
  assign in_ahead  = (ahead_q[31:6] == '0) && (ahead_q[5:0] < cfg_i.win);
  assign in_behind = (behind_q[31:6] == '0) && (behind_q[5:0] != '0) &&
                     (behind_q[5:0] <= cfg_i.win);
  assign in_win    = in_ahead || in_behind;

  assign ok_item     = !done_q && (item_q.cls != CLS_BAD);
  assign fin_ok      = ok_item && (item_q.cls == CLS_FIN) && zero;
  assign gbn_deliver = ok_item && (item_q.cls == CLS_DATA) && !cfg_i.mode_sr && zero;
  assign do_store    = ok_item && (item_q.cls == CLS_DATA) && cfg_i.mode_sr &&
                       in_ahead && !valid_q[slot_q];

  // base slot follows window_base mod slot count, also across the 32-bit wrap
  assign next_mod = ((base_q == '1) || (base_mod_q == SW'(SLOT_COUNT - 1))) ?
                    '0 : base_mod_q + 1'b1;
  assign drain_last = (k_q == SW'(SLOT_COUNT - 1)) || !valid_q[next_mod];

  // slot of seq: base slot plus offset, corrected when the packet number wrapped
  assign ovf  = (pnum_q < base_q);
  assign d6   = pnum_q[5:0] - base_q[5:0];
  assign sum0 = SUMW'(base_mod_q) + SUMW'(d6) + (ovf ? SUMW'(CORR) : '0);
  assign sum1 = (sum0 >= SUMW'(SLOT_COUNT)) ? sum0 - SUMW'(SLOT_COUNT) : sum0;
  assign sum2 = (sum1 >= SUMW'(SLOT_COUNT)) ? sum1 - SUMW'(SLOT_COUNT) : sum1;

  assign slot_x = {5'b0, slot_q};
  assign base_x = {5'b0, base_mod_q};

  assign in_pop_o = (state_q == ST_IDLE) && in_valid_i;
  assign go       = out_push_o && !out_full_i;

  always_comb begin
    out_res_o  = '0;
    out_push_o = 1'b0;
    unique case (state_q)
      ST_DEC: begin
        out_push_o     = 1'b1;
        out_res_o.last = 1'b1;
        if (!ok_item) begin
          out_res_o.kind = KIND_DROP;
        end else if (item_q.cls == CLS_FIN) begin
          if (zero) begin
            out_res_o.kind    = KIND_FINACK;
            out_res_o.ack_seq = item_q.seq;
          end
        end else if (!cfg_i.mode_sr) begin
          if (zero) begin
            out_res_o.kind  = KIND_DELIVER_DIRECT;
            out_res_o.bytes = item_q.plen;
            out_res_o.last  = 1'b0;
          end else if (in_win) begin
            out_res_o.kind    = KIND_ACK;
            out_res_o.ack_seq = exp_q;
          end
        end else if (in_win) begin
          out_res_o.kind    = KIND_ACK;
          out_res_o.ack_seq = item_q.seq;
          out_res_o.last    = !do_store;
        end
      end
      ST_ACK: begin
        out_push_o        = 1'b1;
        out_res_o.kind    = KIND_ACK;
        out_res_o.ack_seq = exp_q + 32'd1;
        out_res_o.last    = 1'b1;
      end
      ST_STORE: begin
        out_push_o      = 1'b1;
        out_res_o.kind  = KIND_STORE;
        out_res_o.slot  = slot_x[4:0];
        out_res_o.bytes = item_q.plen;
        out_res_o.last  = !zero;
      end
      ST_DRN_EM: begin
        out_push_o      = 1'b1;
        out_res_o.kind  = KIND_DELIVER_SLOT;
        out_res_o.slot  = base_x[4:0];
        out_res_o.bytes = rd_q;
        out_res_o.last  = drain_last;
      end
      default: begin
        out_push_o = 1'b0;
      end
    endcase
  end

  // slot length memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_STORE) && go) begin
      len_mem_q[slot_q] <= item_q.plen;
    end
    if (state_q == ST_DRN_RD) begin
      rd_q <= len_mem_q[base_mod_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_EXP) begin
      exp_q  <= base_q + cfg_i.init_seq;
      pnum_q <= item_q.seq - cfg_i.init_seq;
    end
    if (state_q == ST_CMP) begin
      ahead_q  <= item_q.seq - exp_q;
      behind_q <= exp_q - item_q.seq;
      slot_q   <= sum2[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      base_q     <= 32'd1;
      base_mod_q <= BASE_MOD_RST;
      done_q     <= 1'b0;
      valid_q    <= '0;
      k_q        <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXP;
          end
        end
        ST_EXP: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          if (go) begin
            if (gbn_deliver) begin
              valid_q[base_mod_q] <= 1'b0;
              base_q              <= base_q + 32'd1;
              base_mod_q          <= next_mod;
              state_q             <= ST_ACK;
            end else if (fin_ok) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else if (do_store) begin
              state_q <= ST_STORE;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ACK: begin
          if (go) begin
            state_q <= ST_IDLE;
          end
        end
        ST_STORE: begin
          if (go) begin
            valid_q[slot_q] <= 1'b1;
            k_q             <= '0;
            state_q         <= zero ? ST_DRN_RD : ST_IDLE;
          end
        end
        ST_DRN_RD: begin
          state_q <= ST_DRN_EM;
        end
        ST_DRN_EM: begin
          if (go) begin
            valid_q[base_mod_q] <= 1'b0;
            base_q              <= base_q + 32'd1;
            base_mod_q          <= next_mod;
            k_q                 <= k_q + 1'b1;
            state_q             <= drain_last ? ST_IDLE : ST_DRN_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/sliding_window_receiver.sv]
// Sliding-window receiver: one packet header per input transaction, one or
// more result transactions per packet (drop, ack, fin-ack, store, deliver),
// the final one flagged by last_result_o. A two-entry input queue and a
// four-entry result queue decouple the ports from the sequencer; full rises
// once two packets wait behind the one the sequencer is working on. Each
// packet passes the load, expected sequence and distances steps before its
// first result, then emits its results in turn, waiting while the result
// queue is full; an in-order drain reads each slot length from the
// registered read port of the slot length memory, then emits that slot.
// The slot length memory has no reset and no clearing pass; slot valid bits
// live in flip-flops and are cleared by reset.
module sliding_window_receiver
  import swr_pkg::*;
  #(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
  )
  (
    input  logic        clk_i,
    input  logic        rst_ni,
    // configuration write channel
    input  logic        cfg_valid_i,
    output logic        cfg_ready_o,
    input  logic [1:0]  cfg_index_i,
    input  logic [31:0] cfg_data_i,
    // packet header input queue side
    input  logic        push,
    output logic        full,
    input  logic [31:0] seq_number_i,
    input  logic [15:0] payload_length_i,
    input  logic [10:0] received_bytes_i,
    input  logic        checksum_good_i,
    input  logic        flag_syn_i,
    input  logic        flag_ack_i,
    input  logic        flag_fin_i,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind_o,
    output logic [31:0] ack_sequence_o,
    output logic [4:0]  slot_index_o,
    output logic [10:0] data_bytes_o,
    output logic        last_result_o
  );

  localparam int IN_Q_DEPTH  = 2;
  localparam int OUT_Q_DEPTH = 4;
  localparam int ITEM_W      = $bits(item_t);
  localparam int RES_W       = $bits(result_t);

  // configuration registers
  logic        mode_q;
  logic [5:0]  wsize_q;
  logic [31:0] init_q;
  cfg_t        cfg;

  // front to back queue
  item_t             front_item;
  logic [ITEM_W-1:0] in_q_data;
  logic              in_q_empty, in_q_pop;

  // back to result queue
  result_t          back_res, head_res;
  logic [RES_W-1:0] out_q_data;
  logic             out_push, out_full;

  // writes must only arrive while idle, which the block leaves to the user; the channel is always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      wsize_q <= 6'd8;
      init_q  <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q  <= cfg_data_i[0];
        CFG_WINDOW: wsize_q <= cfg_data_i[5:0];
        CFG_INIT:   init_q  <= cfg_data_i;
        default:    mode_q  <= mode_q;
      endcase
    end
  end

  // effective window: zero acts as one, clamped to the slot count so the
  // ring never aliases
  always_comb begin
    cfg.mode_sr  = mode_q;
    cfg.init_seq = init_q;
    if (wsize_q == '0) begin
      cfg.win = 6'd1;
    end else if (wsize_q > 6'(SLOT_COUNT)) begin
      cfg.win = 6'(SLOT_COUNT);
    end else begin
      cfg.win = wsize_q;
    end
  end

  // front: length, checksum and flag checks that need no window state
  swr_front #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .seq_number_i     (seq_number_i),
    .payload_length_i (payload_length_i),
    .received_bytes_i (received_bytes_i),
    .checksum_good_i  (checksum_good_i),
    .flag_syn_i       (flag_syn_i),
    .flag_ack_i       (flag_ack_i),
    .flag_fin_i       (flag_fin_i),
    .item_o           (front_item)
  );

  // classified packets wait here for the sequencer
  swr_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (IN_Q_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (in_q_pop),
    .data_o  (in_q_data),
    .empty_o (in_q_empty)
  );

  // back: window checks, slot ring, in-order drain
  swr_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (!in_q_empty),
    .in_item_i  (item_t'(in_q_data)),
    .in_pop_o   (in_q_pop),
    .out_push_o (out_push),
    .out_res_o  (back_res),
    .out_full_i (out_full)
  );

  // results stay here until the consumer pops them
  swr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_q_data),
    .empty_o (empty)
  );

  // head of the result queue on the ports
  assign head_res       = result_t'(out_q_data);
  assign result_kind_o  = head_res.kind;
  assign ack_sequence_o = head_res.ack_seq;
  assign slot_index_o   = head_res.slot;
  assign data_bytes_o   = head_res.bytes;
  assign last_result_o  = head_res.last;

endmodule

[rtl/swr_checker.sv]
`include "sliding_window_receiver_assert.svh"

module swr_checker
  import swr_pkg::*;
  (
    input logic        clk_i,
    input logic        rst_ni,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  result_kind_o,
    input logic [31:0] ack_sequence_o,
    input logic [4:0]  slot_index_o,
    input logic [10:0] data_bytes_o,
    input logic        last_result_o
  );

  // a waiting result holds until popped
  `SWR_ASSERT_CLK(a_res_hold, !empty && !pop |=> !empty && $stable(result_kind_o) && $stable(ack_sequence_o) && $stable(data_bytes_o) && $stable(last_result_o), "result changed while waiting")

  // result queue is empty while reset is applied
  `SWR_ASSERT_RST(a_rst_empty, !rst_ni |-> empty, "result queue not empty in reset")

  // no result kind beyond deliver direct
  `SWR_ASSERT_CLK(a_kind_range, !empty |-> result_kind_o <= KIND_DELIVER_DIRECT, "bad result kind")

  // drop and fin-ack always close a packet
  `SWR_ASSERT_CLK(a_drop_last, !empty && (result_kind_o == KIND_DROP || result_kind_o == KIND_FINACK) |-> last_result_o, "drop or fin-ack not last")

  // control results carry no slot and no length
  `SWR_ASSERT_CLK(a_ctrl_clean, !empty && (result_kind_o == KIND_DROP || result_kind_o == KIND_ACK || result_kind_o == KIND_FINACK) |-> slot_index_o == 5'd0 && data_bytes_o == 11'd0, "control result with payload fields")

endmodule

bind sliding_window_receiver swr_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import swr_pkg::*;

  // one packet header as it goes onto the input ports
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] plen;
    logic [10:0] rbytes;
    logic        csum;
    logic        syn;
    logic        ack;
    logic        fin;
  } hdr_t;

  // one line of the directed plan: a register write or a packet whose
  // sequence number is an offset from the sequence expected at send time
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    hdr_t        hdr;
    logic        drop_only;
  } row_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 2 * SLOT_COUNT_DEF + 16;
  localparam int PHASE_ITEMS  = 14;
  localparam int PHASES       = 7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_MODE;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] seq_number_i = '0;
  logic [15:0] payload_length_i = '0;
  logic [10:0] received_bytes_i = '0;
  logic        checksum_good_i = 1'b0;
  logic        flag_syn_i = 1'b0;
  logic        flag_ack_i = 1'b0;
  logic        flag_fin_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  result_kind_o;
  logic [31:0] ack_sequence_o;
  logic [4:0]  slot_index_o;
  logic [10:0] data_bytes_o;
  logic        last_result_o;

  // receive-side shadow state and register copy
  logic        cfg_mode = 1'b1;
  logic [5:0]  cfg_win = 6'd8;
  logic [31:0] cfg_init = '0;
  logic [31:0] rx_base = 32'd1;
  logic        slot_busy [SLOT_COUNT_DEF] = '{default: 1'b0};
  logic [10:0] slot_len [SLOT_COUNT_DEF];
  logic        rx_done = 1'b0;

  result_t step_results[$];   // results of the packet just taken
  result_t results_due[$];    // results still owed by the block, oldest first
  row_t    plan[$];
  int      closing_at;
  int      mismatches = 0;
  bit      steady = 1'b0;     // no idling on either side while set
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  sliding_window_receiver DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .seq_number_i     (seq_number_i),
    .payload_length_i (payload_length_i),
    .received_bytes_i (received_bytes_i),
    .checksum_good_i  (checksum_good_i),
    .flag_syn_i       (flag_syn_i),
    .flag_ack_i       (flag_ack_i),
    .flag_fin_i       (flag_fin_i),
    .empty            (empty),
    .pop              (pop),
    .result_kind_o    (result_kind_o),
    .ack_sequence_o   (ack_sequence_o),
    .slot_index_o     (slot_index_o),
    .data_bytes_o     (data_bytes_o),
    .last_result_o    (last_result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // window register as the block uses it: zero acts as one, capped at the ring
  function automatic int eff_window();
    int w;
    w = cfg_win;
    if (w == 0) w = 1;
    if (w > SLOT_COUNT_DEF) w = SLOT_COUNT_DEF;
    return w;
  endfunction

  function automatic void note(kind_e kind, logic [31:0] ack_seq, logic [4:0] slot,
                               logic [10:0] bytes);
    result_t r;
    r.kind    = kind;
    r.ack_seq = ack_seq;
    r.slot    = slot;
    r.bytes   = bytes;
    r.last    = 1'b0;
    step_results.push_back(r);
  endfunction

  // works out every result one packet causes and updates the shadow state
  function automatic void receive_packet(hdr_t h);
    logic [31:0] exp_seq;
    logic [31:0] ahead;
    logic [31:0] behind;
    logic [31:0] pnum;
    int          w;
    int          s;
    int          b;
    bit          fwd;
    bit          back;
    step_results.delete();
    exp_seq = rx_base + cfg_init;
    w       = eff_window();
    ahead   = h.seq - exp_seq;
    behind  = exp_seq - h.seq;
    fwd     = ahead < w;
    back    = behind >= 1 && behind <= w;
    if (rx_done || h.plen > MAX_PAYLOAD_DEF ||
        int'(h.plen) + HEADER_BYTES_DEF != int'(h.rbytes) || !h.csum) begin
      note(KIND_DROP, '0, '0, '0);
    end else if (h.fin && !h.syn && !h.ack) begin
      // only a lone fin at the expected sequence closes the transfer
      if (h.seq == exp_seq) begin
        note(KIND_FINACK, h.seq, '0, '0);
        rx_done = 1'b1;
      end else begin
        note(KIND_DROP, '0, '0, '0);
      end
    end else if (h.syn || h.ack || h.fin) begin
      note(KIND_DROP, '0, '0, '0);
    end else if (!cfg_mode) begin
      // go-back-n: in-order packets go straight out, acks are cumulative
      if (h.seq == exp_seq) begin
        slot_busy[rx_base % SLOT_COUNT_DEF] = 1'b0;
        note(KIND_DELIVER_DIRECT, '0, '0, h.plen[10:0]);
        rx_base++;
        note(KIND_ACK, rx_base + cfg_init, '0, '0);
      end else if (fwd || back) begin
        note(KIND_ACK, exp_seq, '0, '0);
      end else begin
        note(KIND_DROP, '0, '0, '0);
      end
    end else if (!fwd && !back) begin
      note(KIND_DROP, '0, '0, '0);
    end else begin
      // selective repeat: ack by own sequence, park ahead packets in the ring
      note(KIND_ACK, h.seq, '0, '0);
      pnum = h.seq - cfg_init;
      s    = pnum % SLOT_COUNT_DEF;
      if (fwd && !slot_busy[s]) begin
        slot_busy[s] = 1'b1;
        slot_len[s]  = h.plen[10:0];
        note(KIND_STORE, '0, s[4:0], h.plen[10:0]);
        if (ahead == 0) begin
          for (int k = 0; k < SLOT_COUNT_DEF; k++) begin
            b = rx_base % SLOT_COUNT_DEF;
            if (!slot_busy[b]) break;
            note(KIND_DELIVER_SLOT, '0, b[4:0], slot_len[b]);
            slot_busy[b] = 1'b0;
            rx_base++;
          end
        end
      end
    end
    step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // random header: mostly clean data near the window, some noise
  function automatic hdr_t make_header();
    hdr_t        h;
    logic [31:0] exp_seq;
    int          w;
    int          pick;
    exp_seq = rx_base + cfg_init;
    w       = eff_window();
    pick    = $urandom_range(99);
    if (pick < 30) h.seq = exp_seq;
    else if (pick < 65) h.seq = exp_seq + (w > 1 ? $urandom_range(1, w - 1) : 0);
    else if (pick < 80) h.seq = exp_seq - $urandom_range(1, w);
    else if (pick < 88) h.seq = exp_seq + w;
    else h.seq = $urandom();
    {h.syn, h.ack, h.fin} = 3'b000;
    if ($urandom_range(99) >= 88) {h.syn, h.ack, h.fin} = 3'($urandom_range(1, 7));
    // keep the closing fin for the end of the run
    if (h.fin && !h.syn && !h.ack && h.seq == exp_seq) h.ack = 1'b1;
    if ($urandom_range(99) < 88) begin
      h.plen   = $urandom_range(0, MAX_PAYLOAD_DEF);
      h.rbytes = 11'(h.plen + HEADER_BYTES_DEF);
      h.csum   = 1'b1;
    end else begin
      h.plen   = $urandom_range(0, 65535);
      h.rbytes = $urandom_range(0, 2047);
      h.csum   = $urandom_range(0, 1);
    end
    return h;
  endfunction

  function automatic row_t pkt_row(logic [31:0] offset, logic [15:0] plen,
                                   logic [10:0] rbytes, bit csum, bit syn, bit ack,
                                   bit fin, bit drop_only);
    row_t r;
    r           = '0;
    r.hdr       = {offset, plen, rbytes, csum, syn, ack, fin};
    r.drop_only = drop_only;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // offers one packet and waits for its transaction; push is left high
  task automatic send_pkt(hdr_t h, bit drop_only);
    result_t r;
    if (!steady && $urandom_range(99) < 22) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push             <= 1'b1;
    seq_number_i     <= h.seq;
    payload_length_i <= h.plen;
    received_bytes_i <= h.rbytes;
    checksum_good_i  <= h.csum;
    flag_syn_i       <= h.syn;
    flag_ack_i       <= h.ack;
    flag_fin_i       <= h.fin;
    do @(posedge clk_i); while (full);
    receive_packet(h);
    if (drop_only) begin
      // plain drop, readable straight off the header
      r = '0;
      r.kind = KIND_DROP;
      r.last = 1'b1;
      results_due.push_back(r);
    end else begin
      foreach (step_results[i]) results_due.push_back(step_results[i]);
    end
  endtask

  // block is idle once every owed result is out and the sequencer has settled
  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODE:   cfg_mode = val[0];
      CFG_WINDOW: cfg_win  = val[5:0];
      CFG_INIT:   cfg_init = val;
      default:    ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic walk_plan(int lo, int hi);
    hdr_t h;
    for (int i = lo; i < hi; i++) begin
      if (plan[i].is_cfg) begin
        push <= 1'b0;
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        h     = plan[i].hdr;
        h.seq = h.seq + rx_base + cfg_init;
        send_pkt(h, plan[i].drop_only);
      end
    end
  endtask

  task automatic check_result();
    result_t e;
    if (results_due.size() == 0) begin
      $error("result_kind: expected no transaction, got %0d", result_kind_o);
      mismatches++;
    end else begin
      e = results_due.pop_front();
      if (result_kind_o !== e.kind) begin
        $error("result_kind: expected %0d, got %0d", e.kind, result_kind_o);
        mismatches++;
      end
      if (ack_sequence_o !== e.ack_seq) begin
        $error("ack_sequence: expected %0h, got %0h", e.ack_seq, ack_sequence_o);
        mismatches++;
      end
      if (slot_index_o !== e.slot) begin
        $error("slot_index: expected %0d, got %0d", e.slot, slot_index_o);
        mismatches++;
      end
      if (data_bytes_o !== e.bytes) begin
        $error("data_bytes: expected %0d, got %0d", e.bytes, data_bytes_o);
        mismatches++;
      end
      if (last_result_o !== e.last) begin
        $error("last_result: expected %0d, got %0d", e.last, last_result_o);
        mismatches++;
      end
    end
  endtask

  // result side: check each popped transaction, then pick the next pop
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_result();
      // long hold-off so the result queue backs up into the input side
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    hdr_t        h;
    logic        ph_mode [PHASES];
    logic [5:0]  ph_win  [PHASES];
    logic [31:0] ph_init;

    // reset edge at time zero so the asynchronous reset takes hold at once
    rst_ni  <= 1'b0;
    ph_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    ph_win  = '{6'd8, 6'd1, 6'd32, 6'd63, 6'd0, 6'd3, 6'd5};

    // opening plan, run on the reset settings (selective repeat, window 8)
    //                 offset        plen    rbytes  ok syn ack fin drop
    plan.push_back(pkt_row(32'd0,        16'd0,     11'd11,   1, 0, 0, 0, 0)); // empty payload
    plan.push_back(pkt_row(32'd0,        16'd1461,  11'd1472, 1, 0, 0, 0, 0)); // largest payload
    plan.push_back(pkt_row(32'd0,        16'd1462,  11'd1473, 1, 0, 0, 0, 1)); // too long
    plan.push_back(pkt_row(32'd0,        16'hFFFF,  11'd2047, 1, 0, 0, 0, 1));
    plan.push_back(pkt_row(32'd0,        16'd20,    11'd30,   1, 0, 0, 0, 1)); // length mismatch
    plan.push_back(pkt_row(32'd0,        16'd20,    11'd31,   0, 0, 0, 0, 1)); // bad checksum
    plan.push_back(pkt_row(32'd0,        16'd20,    11'd31,   1, 1, 0, 0, 1)); // syn
    plan.push_back(pkt_row(32'd0,        16'd20,    11'd31,   1, 0, 1, 0, 1)); // ack
    plan.push_back(pkt_row(32'd0,        16'd20,    11'd31,   1, 0, 1, 1, 1)); // fin with ack
    plan.push_back(pkt_row(32'd1,        16'd20,    11'd31,   1, 0, 0, 1, 1)); // early fin
    plan.push_back(pkt_row(32'd2,        16'd100,   11'd111,  1, 0, 0, 0, 0)); // out of order
    plan.push_back(pkt_row(32'd2,        16'd101,   11'd112,  1, 0, 0, 0, 0)); // duplicate
    plan.push_back(pkt_row(32'd1,        16'd102,   11'd113,  1, 0, 0, 0, 0));
    plan.push_back(pkt_row(32'hFFFFFFFF, 16'd7,     11'd18,   1, 0, 0, 0, 0)); // just behind
    plan.push_back(pkt_row(32'd7,        16'd8,     11'd19,   1, 0, 0, 0, 0)); // window edge
    plan.push_back(pkt_row(32'd8,        16'd9,     11'd20,   1, 0, 0, 0, 0)); // past window
    plan.push_back(pkt_row(32'd0,        16'd50,    11'd61,   1, 0, 0, 0, 0)); // drains three
    plan.push_back(cfg_row(CFG_MODE, 32'd0));                                  // go-back-n
    plan.push_back(pkt_row(32'd0,        16'd5,     11'd16,   1, 0, 0, 0, 0));
    plan.push_back(pkt_row(32'd3,        16'd5,     11'd16,   1, 0, 0, 0, 0));
    plan.push_back(pkt_row(32'hFFFFFFF8, 16'd5,     11'd16,   1, 0, 0, 0, 0)); // behind by w
    plan.push_back(pkt_row(32'hFFFFFFF7, 16'd5,     11'd16,   1, 0, 0, 0, 0)); // too far back
    closing_at = plan.size();
    // closing plan: a fin with a bad checksum, the fin at the expected sequence, then only drops
    plan.push_back(pkt_row(32'd0,        16'd0,     11'd11,   0, 0, 0, 1, 1));
    plan.push_back(pkt_row(32'd0,        16'd0,     11'd11,   1, 0, 0, 1, 0));
    plan.push_back(pkt_row(32'd0,        16'd40,    11'd51,   1, 0, 0, 0, 1));
    plan.push_back(pkt_row(32'd0,        16'd0,     11'd11,   1, 0, 0, 1, 1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    walk_plan(0, closing_at);

    // random phases over mode, window extremes and sequence wrap
    for (int ph = 0; ph < PHASES; ph++) begin
      push <= 1'b0;
      steady = 1'b0;
      wait_drained();
      case (ph)
        1:       ph_init = 32'hFFFF_FFF0;
        2:       ph_init = 32'hFFFF_FFFF;
        5:       ph_init = 32'h0;
        default: ph_init = $urandom();
      endcase
      write_reg(CFG_MODE, {31'd0, ph_mode[ph]});
      write_reg(CFG_WINDOW, {26'd0, ph_win[ph]});
      write_reg(CFG_INIT, ph_init);
      steady = (ph == 2);
      if (ph == PHASES - 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        h = make_header();
        send_pkt(h, 1'b0);
      end
    end

    push <= 1'b0;
    steady = 1'b0;
    wait_drained();
    walk_plan(closing_at, plan.size());
    push <= 1'b0;
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
